>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Every module that uses them has a clock named i_clk and an active-low reset
// named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/mbr_pkg.sv
package mbr_pkg;

    // Default sizing of the block.
    localparam int MAX_TRIANGLES_DEF = 64;
    localparam int COORD_WIDTH_DEF   = 32;

    // Largest store the job descriptor can describe.
    localparam int MAX_TRIANGLES_LIMIT = 64;
    localparam int JOB_CNT_W           = $clog2(MAX_TRIANGLES_LIMIT + 1);

    // Geometry of one triangle.
    localparam int NUM_AXES   = 3;
    localparam int NUM_COORDS = 9;
    localparam int CIDX_W     = $clog2(NUM_COORDS + 1);

    // Fixed-point formats of the scale factor and the target extent.
    localparam int FRAC_W    = 16;
    localparam int FACTOR_W  = 32;
    localparam int TGT_W     = 31;
    localparam int DIV_DVD_W = TGT_W + FRAC_W;

    localparam logic [TGT_W-1:0]    TGT_RESET  = TGT_W'(65536);
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(65536);

    // Depth of the descriptor queue between the front and back parts.
    localparam int Q_DEPTH = 2;

    // Control part of one mesh job handed from the front to the back.
    typedef struct packed {
        logic                 bank;
        logic [JOB_CNT_W-1:0] count;
        logic                 dropped;
    } t_job_ctl;

    // Bits needed to index n entries (at least one).
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> sv/mbr_div.sv
`include "assert_macros.svh"

module mbr_div
    import mbr_pkg::*;
#(
    parameter int DVS_W = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]     i_divisor,
    output logic                 o_done,
    output logic [DIV_DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIV_DVD_W);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [DIV_DVD_W-1:0] r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           ge;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of r_quo while quotient bits shift in at the bottom.
    always_comb begin
        shifted = {r_rem, r_quo[DIV_DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_DVD_W-2:0], ge};
                r_rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `ASSERT_IMPL(a_div_no_restart, i_start, !r_busy, "divider restarted while busy")

endmodule

>>> sv/mbr_front.sv
`include "assert_macros.svh"

module mbr_front
    import mbr_pkg::*;
#(
    parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic                                    i_mesh_end,
    input  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0]  i_coords,
    input  logic                                    i_q_full,
    output logic                                    o_stall,
    output logic                                    o_wr_en,
    output logic [idx_width(MAX_TRIANGLES):0]       o_wr_addr,
    output logic [NUM_COORDS-1:0][COORD_WIDTH-1:0]  o_wr_data,
    output logic                                    o_push,
    output t_job_ctl                                o_push_ctl,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]    o_push_min,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]    o_push_max
);

    localparam int IDX_W     = idx_width(MAX_TRIANGLES);
    localparam int TRI_CNT_W = $clog2(MAX_TRIANGLES + 1);

    localparam logic [COORD_WIDTH-1:0] COORD_MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic                                 r_bank;
    logic [TRI_CNT_W-1:0]                 r_count;
    logic                                 r_dropped;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_min;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_max;

    logic                                 accept;
    logic                                 full;
    logic                                 store;
    logic [TRI_CNT_W-1:0]                 n_count;
    logic                                 n_dropped;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] n_min;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] n_max;

    function automatic logic [COORD_WIDTH-1:0] smin(input logic [COORD_WIDTH-1:0] a,
                                                   input logic [COORD_WIDTH-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] smax(input logic [COORD_WIDTH-1:0] a,
                                                   input logic [COORD_WIDTH-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    always_comb begin
        accept    = i_valid && !i_q_full;
        full      = (r_count == TRI_CNT_W'(MAX_TRIANGLES));
        store     = accept && !full;
        n_count   = store ? r_count + TRI_CNT_W'(1) : r_count;
        n_dropped = r_dropped || (accept && full);
        for (int a = 0; a < NUM_AXES; a++) begin
            if (store) begin
                n_min[a] = smin(smin(r_min[a], i_coords[a]),
                                smin(i_coords[NUM_AXES + a], i_coords[2*NUM_AXES + a]));
                n_max[a] = smax(smax(r_max[a], i_coords[a]),
                                smax(i_coords[NUM_AXES + a], i_coords[2*NUM_AXES + a]));
            end else begin
                n_min[a] = r_min[a];
                n_max[a] = r_max[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_min     <= {NUM_AXES{COORD_MAXV}};
            r_max     <= {NUM_AXES{COORD_MINV}};
        end else if (accept) begin
            if (i_mesh_end) begin
                // The mesh is handed over; start a fresh one in the other bank.
                r_bank    <= !r_bank;
                r_count   <= '0;
                r_dropped <= 1'b0;
                r_min     <= {NUM_AXES{COORD_MAXV}};
                r_max     <= {NUM_AXES{COORD_MINV}};
            end else begin
                r_count   <= n_count;
                r_dropped <= n_dropped;
                r_min     <= n_min;
                r_max     <= n_max;
            end
        end
    end

    assign o_stall    = i_q_full;
    assign o_wr_en    = store;
    assign o_wr_addr  = {r_bank, r_count[IDX_W-1:0]};
    assign o_wr_data  = i_coords;
    assign o_push     = accept && i_mesh_end;
    assign o_push_min = n_min;
    assign o_push_max = n_max;

    always_comb begin
        o_push_ctl.bank    = r_bank;
        o_push_ctl.count   = JOB_CNT_W'(n_count);
        o_push_ctl.dropped = n_dropped;
    end

    `ASSERT_ALWAYS(a_count_range, r_count <= TRI_CNT_W'(MAX_TRIANGLES),
        "triangle count beyond the store capacity")

endmodule

>>> sv/mbr_queue.sv
`include "assert_macros.svh"

module mbr_queue
    import mbr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  t_job_ctl                             i_push_ctl,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] i_push_min,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] i_push_max,
    input  logic                                 i_pop,
    output logic                                 o_valid,
    output logic                                 o_full,
    output t_job_ctl                             o_head_ctl,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] o_head_min,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] o_head_max
);

    localparam int PTR_W = idx_width(Q_DEPTH);
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    t_job_ctl                             r_ctl [Q_DEPTH];
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_min [Q_DEPTH];
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_max [Q_DEPTH];
    logic [PTR_W-1:0]                     r_wr_ptr;
    logic [PTR_W-1:0]                     r_rd_ptr;
    logic [QCNT_W-1:0]                    r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_ctl[r_wr_ptr] <= i_push_ctl;
                r_min[r_wr_ptr] <= i_push_min;
                r_max[r_wr_ptr] <= i_push_max;
                r_wr_ptr        <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_valid    = (r_count != '0);
    assign o_full     = (r_count == QCNT_W'(Q_DEPTH));
    assign o_head_ctl = r_ctl[r_rd_ptr];
    assign o_head_min = r_min[r_rd_ptr];
    assign o_head_max = r_max[r_rd_ptr];

    `ASSERT_IMPL(a_no_push_full, i_push, !o_full, "job pushed into a full queue")
    `ASSERT_IMPL(a_no_pop_empty, i_pop, o_valid, "job popped from an empty queue")

endmodule

>>> sv/mbr_back.sv
`include "assert_macros.svh"

module mbr_back
    import mbr_pkg::*;
#(
    parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [TGT_W-1:0]                       i_target,
    input  logic                                   i_q_valid,
    input  t_job_ctl                               i_q_ctl,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   i_q_min,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   i_q_max,
    output logic                                   o_q_pop,
    output logic                                   o_rd_en,
    output logic [idx_width(MAX_TRIANGLES):0]      o_rd_addr,
    input  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] i_rd_data,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] o_coords,
    output logic                                   o_run_last,
    output logic                                   o_capacity_exceeded
);

    localparam int IDX_W     = idx_width(MAX_TRIANGLES);
    localparam int TRI_CNT_W = $clog2(MAX_TRIANGLES + 1);
    localparam int PROD_W    = COORD_WIDTH + FRAC_W;

    localparam logic [COORD_WIDTH-1:0] COORD_MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_EXT,
        S_DIV,
        S_READ,
        S_CALC,
        S_LOAD
    } t_state;

    t_state                                 r_state;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   r_diff;
    logic [FACTOR_W-1:0]                    r_factor;
    logic [IDX_W-1:0]                       r_k;
    logic [CIDX_W-1:0]                      r_iss;
    logic                                   r_a_vld;
    logic [CIDX_W-1:0]                      r_a_idx;
    logic                                   r_a_neg;
    logic [COORD_WIDTH-1:0]                 r_a_mag;
    logic                                   r_b_vld;
    logic [CIDX_W-1:0]                      r_b_idx;
    logic                                   r_b_neg;
    logic [PROD_W-1:0]                      r_b_hi;
    logic [PROD_W-1:0]                      r_b_lo;
    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] r_acc;
    logic                                   r_out_vld;
    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] r_out;
    logic                                   r_out_last;
    logic                                   r_out_drop;

    logic [NUM_AXES-1:0][COORD_WIDTH:0] diff_full;
    logic [COORD_WIDTH-1:0]             ext_xy;
    logic [COORD_WIDTH-1:0]             ext_w;
    logic                               div_start;
    logic                               div_done;
    logic [DIV_DVD_W-1:0]               div_quo;
    logic [FACTOR_W-1:0]                quo_sat;
    logic                               issue;
    logic [COORD_WIDTH-1:0]             sel_coord;
    logic [COORD_WIDTH-1:0]             sel_mag;
    logic [PROD_W-1:0]                  prod;
    logic                               ovf;
    logic [COORD_WIDTH-1:0]             scaled;
    logic                               out_free;
    logic                               is_last;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            diff_full[a] = {i_q_max[a][COORD_WIDTH-1], i_q_max[a]}
                         - {i_q_min[a][COORD_WIDTH-1], i_q_min[a]};
        end
        ext_xy = (r_diff[1] > r_diff[0]) ? r_diff[1] : r_diff[0];
        ext_w  = (r_diff[2] > ext_xy) ? r_diff[2] : ext_xy;

        div_start = (r_state == S_EXT) && (ext_w != '0);
        quo_sat   = (|div_quo[DIV_DVD_W-1:FACTOR_W]) ? '1 : div_quo[FACTOR_W-1:0];

        issue     = (r_state == S_CALC) && (r_iss < CIDX_W'(NUM_COORDS));
        sel_coord = i_rd_data[r_iss];
        sel_mag   = sel_coord[COORD_WIDTH-1] ? (~sel_coord + COORD_WIDTH'(1)) : sel_coord;

        // Truncated magnitude of coordinate times factor, then saturation.
        prod = r_b_hi + (r_b_lo >> FRAC_W);
        ovf  = |prod[PROD_W-1:COORD_WIDTH-1];
        if (r_b_neg) begin
            scaled = ovf ? COORD_MINV : (~prod[COORD_WIDTH-1:0] + COORD_WIDTH'(1));
        end else begin
            scaled = ovf ? COORD_MAXV : prod[COORD_WIDTH-1:0];
        end

        out_free = !r_out_vld || !i_stall;
        is_last  = ((TRI_CNT_W'(r_k) + TRI_CNT_W'(1)) == i_q_ctl.count[TRI_CNT_W-1:0]);
    end

    mbr_div #(
        .DVS_W(COORD_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({i_target, {FRAC_W{1'b0}}}),
        .i_divisor  (ext_w),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_iss     <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // Coordinate pipeline: magnitude, partial products, saturation.
            r_a_vld <= issue;
            r_a_idx <= r_iss;
            r_a_neg <= sel_coord[COORD_WIDTH-1];
            r_a_mag <= sel_mag;
            r_b_vld <= r_a_vld;
            r_b_idx <= r_a_idx;
            r_b_neg <= r_a_neg;
            r_b_hi  <= {{FRAC_W{1'b0}}, r_a_mag}
                     * {{COORD_WIDTH{1'b0}}, r_factor[FACTOR_W-1:FRAC_W]};
            r_b_lo  <= {{FRAC_W{1'b0}}, r_a_mag}
                     * {{COORD_WIDTH{1'b0}}, r_factor[FRAC_W-1:0]};
            if (r_b_vld) begin
                r_acc[r_b_idx] <= scaled;
            end
            if (issue) begin
                r_iss <= r_iss + CIDX_W'(1);
            end

            if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_diff[a] <= diff_full[a][COORD_WIDTH-1:0];
                    end
                    r_state <= S_EXT;
                end
                S_EXT: begin
                    r_k <= '0;
                    if (ext_w == '0) begin
                        r_factor <= FACTOR_ONE;
                        r_state  <= S_READ;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_factor <= quo_sat;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_iss   <= '0;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (r_b_vld && (r_b_idx == CIDX_W'(NUM_COORDS - 1))) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out      <= r_acc;
                        r_out_last <= is_last;
                        r_out_drop <= i_q_ctl.dropped;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + IDX_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_q_pop             = (r_state == S_LOAD) && out_free && is_last;
    assign o_rd_en             = (r_state == S_READ);
    assign o_rd_addr           = {i_q_ctl.bank, r_k};
    assign o_valid             = r_out_vld;
    assign o_coords            = r_out;
    assign o_run_last          = r_out_last;
    assign o_capacity_exceeded = r_out_drop;

    `ASSERT_IMPL(a_busy_has_job, r_state != S_IDLE, i_q_valid,
        "emit engine working without a queued job")

endmodule

>>> sv/mesh_bounding_box_rescale_core.sv
// Mesh bounding-box rescaler.
// Triangles arrive on the input channel (i_valid / o_stall), one transfer per
// triangle with nine signed Q15.16 coordinates and i_mesh_end on the last one.
// Each triangle is taken in the cycle it arrives unless o_stall is high; the
// per-axis bounds are tracked on the fly. When a mesh ends, the block divides
// the target extent (written over i_cfg_valid / o_cfg_ready / i_cfg_data) by
// the largest axis extent (the division is skipped and the factor is 1.0 when
// all vertices coincide), and then replays every stored triangle scaled, one
// triangle at a time. The divider runs one quotient bit per cycle and the
// replay is paced by the single coordinate pipeline, one coordinate per cycle.
// The store holds two banks of MAX_TRIANGLES triangles, so the next mesh loads
// while the previous one is replayed; o_stall rises only when both banks hold
// meshes that still wait for replay. Triangles beyond capacity are dropped and
// flagged on every result of that mesh.
// Results (o_valid / i_stall) sit in an output register; a stalled result holds
// steady while the next triangle is already computed behind it.
// Reset is synchronous; it empties the queue and the bounds and sets the
// target extent to 1.0. The store itself needs no clearing.
module mesh_bounding_box_rescale_core
    import mbr_pkg::*;
#(
    parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [TGT_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_v0_x,
    input  logic signed [COORD_WIDTH-1:0] i_v0_y,
    input  logic signed [COORD_WIDTH-1:0] i_v0_z,
    input  logic signed [COORD_WIDTH-1:0] i_v1_x,
    input  logic signed [COORD_WIDTH-1:0] i_v1_y,
    input  logic signed [COORD_WIDTH-1:0] i_v1_z,
    input  logic signed [COORD_WIDTH-1:0] i_v2_x,
    input  logic signed [COORD_WIDTH-1:0] i_v2_y,
    input  logic signed [COORD_WIDTH-1:0] i_v2_z,
    input  logic                          i_mesh_end,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_s0_x,
    output logic signed [COORD_WIDTH-1:0] o_s0_y,
    output logic signed [COORD_WIDTH-1:0] o_s0_z,
    output logic signed [COORD_WIDTH-1:0] o_s1_x,
    output logic signed [COORD_WIDTH-1:0] o_s1_y,
    output logic signed [COORD_WIDTH-1:0] o_s1_z,
    output logic signed [COORD_WIDTH-1:0] o_s2_x,
    output logic signed [COORD_WIDTH-1:0] o_s2_y,
    output logic signed [COORD_WIDTH-1:0] o_s2_z,
    output logic                          o_run_last,
    output logic                          o_capacity_exceeded
);

    localparam int IDX_W     = idx_width(MAX_TRIANGLES);
    localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

    logic [TGT_W-1:0] r_target_extent;

    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] in_coords;
    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] out_coords;

    // Triangle store: one row per triangle, two banks selected by the top
    // address bit.
    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] r_store [MEM_DEPTH];
    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] r_rd_data;

    logic                                   wr_en;
    logic [IDX_W:0]                         wr_addr;
    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] wr_data;
    logic                                   rd_en;
    logic [IDX_W:0]                         rd_addr;

    logic                                 push;
    t_job_ctl                             push_ctl;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] push_min;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] push_max;
    logic                                 pop;
    logic                                 q_valid;
    logic                                 q_full;
    t_job_ctl                             head_ctl;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] head_min;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] head_max;

    // The register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_extent <= TGT_RESET;
        end else if (i_cfg_valid) begin
            r_target_extent <= i_cfg_data;
        end
    end

    assign in_coords[0] = i_v0_x;
    assign in_coords[1] = i_v0_y;
    assign in_coords[2] = i_v0_z;
    assign in_coords[3] = i_v1_x;
    assign in_coords[4] = i_v1_y;
    assign in_coords[5] = i_v1_z;
    assign in_coords[6] = i_v2_x;
    assign in_coords[7] = i_v2_y;
    assign in_coords[8] = i_v2_z;

    mbr_front #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_mesh_end (i_mesh_end),
        .i_coords   (in_coords),
        .i_q_full   (q_full),
        .o_stall    (o_stall),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_push_ctl (push_ctl),
        .o_push_min (push_min),
        .o_push_max (push_max)
    );

    // One write port for the loader and one registered read port for the
    // replay engine.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    mbr_queue #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ctl (push_ctl),
        .i_push_min (push_min),
        .i_push_max (push_max),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_full     (q_full),
        .o_head_ctl (head_ctl),
        .o_head_min (head_min),
        .o_head_max (head_max)
    );

    mbr_back #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_target            (r_target_extent),
        .i_q_valid           (q_valid),
        .i_q_ctl             (head_ctl),
        .i_q_min             (head_min),
        .i_q_max             (head_max),
        .o_q_pop             (pop),
        .o_rd_en             (rd_en),
        .o_rd_addr           (rd_addr),
        .i_rd_data           (r_rd_data),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_coords            (out_coords),
        .o_run_last          (o_run_last),
        .o_capacity_exceeded (o_capacity_exceeded)
    );

    assign o_s0_x = out_coords[0];
    assign o_s0_y = out_coords[1];
    assign o_s0_z = out_coords[2];
    assign o_s1_x = out_coords[3];
    assign o_s1_y = out_coords[4];
    assign o_s1_z = out_coords[5];
    assign o_s2_x = out_coords[6];
    assign o_s2_y = out_coords[7];
    assign o_s2_z = out_coords[8];

endmodule
